// ===== rtl/max_priority_queue_macros.svh =====
// Assertion macros used by the priority queue RTL.
`ifndef MAX_PRIORITY_QUEUE_MACROS_SVH
`define MAX_PRIORITY_QUEUE_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define MPQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define MPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mpq_pkg.sv =====
// Types, codes and default sizes of the max priority queue.
package mpq_pkg;

  localparam int unsigned MPQ_DEPTH       = 16;
  localparam int unsigned MPQ_VALUE_WIDTH = 32;
  localparam int unsigned DATA_WIDTH      = 32;
  localparam int unsigned OCC_WIDTH       = 5;

  typedef enum logic {
    CMD_ENQUEUE = 1'b0,
    CMD_DEQUEUE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  typedef struct packed {
    cmd_e                   command;
    logic signed [DATA_WIDTH-1:0] value;
  } mpq_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] result_value;
    status_e                      status;
    logic [OCC_WIDTH-1:0]         occupancy;
  } mpq_out_t;

endpackage

// ===== rtl/max_priority_queue.sv =====
// Max priority queue: unsorted entry store with a scanning comparator.
// Values are stored unsorted in arrival order in a single-port-read,
// single-port-write memory of DEPTH entries. One beat goes in, exactly one
// result beat comes out, and the input is stalled until that item is done.
// An enqueue, or any refused command, goes to the done state, which loads
// the result register once it is free and returns to idle to free the input.
// A dequeue walks the memory with one comparator, one read a cycle, to find
// the largest value (oldest wins a tie), then the same read port moves every
// later entry down one slot. The result register lets the next beat be
// accepted while a finished result still waits.
// Status: 0 ok, 1 enqueue refused (full), 2 dequeue refused (empty, value 0).
module max_priority_queue #(
  parameter int unsigned DEPTH       = mpq_pkg::MPQ_DEPTH,
  parameter int unsigned VALUE_WIDTH = mpq_pkg::MPQ_VALUE_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  mpq_pkg::mpq_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output mpq_pkg::mpq_out_t out_data_o
);
  import mpq_pkg::*;

  `include "max_priority_queue_macros.svh"

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  // Entry store
  logic [VALUE_WIDTH-1:0] mem [DEPTH];
  logic [VALUE_WIDTH-1:0] rdata_q;

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [CNT_W-1:0]       ptr_q, ptr_d;
  logic                   cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]       cmp_idx_q, cmp_idx_d;
  logic [VALUE_WIDTH-1:0] best_q, best_d;
  logic [IDX_W-1:0]       best_idx_q, best_idx_d;
  logic                   wr_pend_q, wr_pend_d;
  logic [IDX_W-1:0]       wr_addr_q, wr_addr_d;
  logic [DATA_WIDTH-1:0]  res_q, res_d;
  status_e                status_q, status_d;
  logic                   out_valid_q, out_valid_d;
  mpq_out_t               out_data_q, out_data_d;

  logic                   in_accept;
  logic                   rd_en;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic [VALUE_WIDTH-1:0] enq_val;
  logic                   take;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Sign-extend or truncate the incoming value to the stored width
  assign enq_val = VALUE_WIDTH'(in_data_i.value);

  // New maximum: first entry, or strictly larger than the best so far
  assign take = (cmp_idx_q == '0) || ($signed(rdata_q) > $signed(best_q));

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    wr_pend_d   = 1'b0;
    wr_addr_d   = wr_addr_q;
    res_d       = res_q;
    status_d    = status_q;
    rd_en       = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = wr_addr_q;
    mem_wdata   = rdata_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          res_d    = '0;
          status_d = STATUS_OK;
          state_d  = ST_DONE;
          if (in_data_i.command == CMD_ENQUEUE) begin
            if (cnt_q == CNT_FULL) begin
              status_d = STATUS_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = cnt_q[IDX_W-1:0];
              mem_wdata = enq_val;
              cnt_d     = cnt_q + CNT_ONE;
            end
          end else if (cnt_q == '0) begin
            status_d = STATUS_EMPTY;
          end else begin
            ptr_d   = '0;
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue one read a cycle, compare the data from the cycle before
        rd_en = (ptr_q < cnt_q);
        if (rd_en) begin
          ptr_d = ptr_q + CNT_ONE;
        end
        cmp_vld_d = rd_en;
        cmp_idx_d = ptr_q[IDX_W-1:0];
        if (cmp_vld_q && take) begin
          best_d     = rdata_q;
          best_idx_d = cmp_idx_q;
        end
        if (!rd_en && cmp_vld_q) begin
          ptr_d   = CNT_W'(best_idx_d) + CNT_ONE;
          state_d = ST_SHIFT;
        end
      end

      ST_SHIFT: begin
        // Read slot i, write it back to slot i-1 in the next cycle
        rd_en = (ptr_q < cnt_q);
        if (rd_en) begin
          ptr_d     = ptr_q + CNT_ONE;
          wr_pend_d = 1'b1;
          wr_addr_d = ptr_q[IDX_W-1:0] - IDX_W'(1);
        end
        if (wr_pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = wr_addr_q;
          mem_wdata = rdata_q;
        end
        if (!rd_en && !wr_pend_q) begin
          cnt_d   = cnt_q - CNT_ONE;
          res_d   = DATA_WIDTH'(best_q);
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        // Load the result register once it is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d           = 1'b1;
          out_data_d.result_value = res_q;
          out_data_d.status     = status_q;
          out_data_d.occupancy  = OCC_WIDTH'(cnt_q);
          state_d               = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ptr_q       <= '0;
      cmp_vld_q   <= 1'b0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      cmp_vld_q   <= cmp_vld_d;
      wr_pend_q   <= wr_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cmp_idx_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    wr_addr_q  <= wr_addr_d;
    res_q      <= res_d;
    status_q   <= status_d;
    out_data_q <= out_data_d;
  end

  // Memory: one registered read and one write per cycle
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[ptr_q[IDX_W-1:0]];
    end
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Assertions
  `MPQ_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= CNT_FULL, "entry count exceeds depth")
  `MPQ_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_accept, in_stall_o, "input not stalled after accept")
  `MPQ_ASSERT_NEXT(a_cnt_stable_scan, clk_i, rst_ni, state_q == ST_SCAN, $stable(cnt_q), "entry count changed during scan")
  `MPQ_ASSERT(a_result_from_done, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == ST_DONE), "result loaded outside done state")

endmodule
